[hw/rtl/bafv_pkg.sv]
// Package for the barometric altitude filter: constants, types and power table function.
`default_nettype none
package bafv_pkg;

  localparam int POWER_TABLE_ENTRIES_DEF = 256;
  localparam logic [15:0] WEIGHT_RESET = 16'd6554;
  localparam logic [16:0] PREF_RESET = 17'd101325;
  localparam int DIV_DW = 36;
  localparam int DIV_VW = 32;

  localparam logic [7:0] REG_WEIGHT = 8'd0;
  localparam logic [7:0] REG_PREF = 8'd1;

  localparam longint EXPONENT_Q30 = 64'sd204333069;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // integer square root, bit by bit
  function automatic longint unsigned bafv_isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned x;
    res = 0;
    x = v;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // table entry i of (2i/n)^0.1903 in Q1.16, evaluated at elaboration
  function automatic logic [16:0] pow_entry(int i, int n);
    longint unsigned rs [31];
    longint unsigned num;
    longint unsigned rem;
    longint unsigned xq;
    longint unsigned x;
    longint unsigned r;
    longint unsigned fu;
    longint e;
    longint frac;
    longint lg;
    longint y;
    longint ip;
    longint sh;
    int b;
    if (i == 0) return 17'd0;
    rs[0] = 64'd1 << 31;
    for (b = 1; b <= 30; b++) rs[b] = bafv_isqrt(rs[b-1] << 30);
    num = longint'(2 * i) << 30;
    rem = 0;
    xq = 0;
    for (b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      xq = xq << 1;
      if (rem >= longint'(n)) begin
        rem = rem - longint'(n);
        xq = xq | 64'd1;
      end
    end
    x = xq;
    e = 0;
    frac = 0;
    while (x >= (64'd1 << 31)) begin
      x = x >> 1;
      e = e + 1;
    end
    while (x < (64'd1 << 30)) begin
      x = x << 1;
      e = e - 1;
    end
    for (b = 29; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | (64'sd1 << b);
      end
    end
    lg = e * (64'sd1 << 30) + frac;
    y = (lg * EXPONENT_Q30) >>> 30;
    ip = y >>> 30;
    fu = longint'(y - ip * (64'sd1 << 30));
    r = 64'd1 << 30;
    for (b = 1; b <= 30; b++)
      if (((fu >> (30 - b)) & 64'd1) != 0) r = (r * rs[b]) >> 30;
    sh = 14 - ip;
    if (sh < 0) sh = 0;
    if (sh >= 63) return 17'd0;
    r = r >> sh;
    return r[16:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/baro_altitude_filter_vspeed_unit.sv]
// Top level: pressure to altitude, exponential smoothing and vertical speed.
// The bit-serial divider, used for the pressure ratio and again for the speed,
// dominates the time from input transaction to result valid. Zero reference
// pressure skips the ratio division. Flow: one item in flight; the next is
// taken the cycle after the result is registered.
// Reset (rst, synchronous): registers to their reset values, state cleared to zero.
`default_nettype none
module baro_altitude_filter_vspeed_unit
  import bafv_pkg::*;
#(
  parameter int POWER_TABLE_ENTRIES = POWER_TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // pressure_pa[16:0], time_ms[48:17], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [55:0] m_tdata,   // altitude[24:0], vertical_speed[48:25], zero pad
  output logic             m_tuser,   // speed_updated
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int IW = $clog2(POWER_TABLE_ENTRIES + 1);
  localparam int NW = IW + 1;
  localparam int PW = 18 + NW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RATIO  = 4'd1;
  localparam logic [3:0] S_POS    = 4'd2;
  localparam logic [3:0] S_INTERP = 4'd3;
  localparam logic [3:0] S_RAW    = 4'd4;
  localparam logic [3:0] S_MIX1   = 4'd5;
  localparam logic [3:0] S_MIX2   = 4'd6;
  localparam logic [3:0] S_SPEED  = 4'd7;
  localparam logic [3:0] S_VDIV   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  // power table, constant logic
  logic [16:0] rom [POWER_TABLE_ENTRIES+1];
  for (genvar g = 0; g <= POWER_TABLE_ENTRIES; g++) begin : g_rom
    assign rom[g] = pow_entry(g, POWER_TABLE_ENTRIES);
  end

  logic [3:0]  state;
  logic [15:0] weight;
  logic [16:0] pref;
  logic [31:0] now_r;
  logic [17:0] ratio;
  logic [IW-1:0] idx;
  logic        idx_top;
  logic [16:0] frac;
  logic [16:0] tval;
  logic signed [24:0] raw;
  logic signed [41:0] prod1;
  logic signed [24:0] filt;
  logic signed [24:0] prev_alt;
  logic [31:0] prev_time;
  logic signed [23:0] held;
  logic        upd;
  logic        neg;

  logic              div_start;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_VW-1:0] div_divisor;
  div_status_t       div_st;
  logic [DIV_DW-1:0] div_q;

  logic s_acc;
  logic m_load;
  assign s_tready = (state == S_IDLE);
  assign s_acc = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  // load the result register once it is free
  assign m_load = (state == S_FIN) && (!m_tvalid || m_tready);

  // datapath terms per state
  logic [PW-1:0]      pos;
  logic [16:0]        lo_v;
  logic [16:0]        hi_v;
  logic [16:0]        dlt;
  logic [33:0]        dprod;
  logic signed [17:0] tdiff;
  logic signed [34:0] aprod;
  logic signed [26:0] ashift;
  logic signed [42:0] prod2;
  logic signed [43:0] mixsum;
  logic signed [27:0] mixsh;
  logic signed [25:0] adiff;
  logic signed [36:0] num;
  logic [35:0]        mag;
  logic [31:0]        dt;

  assign pos = PW'(ratio) * PW'(POWER_TABLE_ENTRIES);
  assign lo_v = rom[idx];
  assign hi_v = rom[idx_top ? idx : IW'(idx + 1'b1)];
  assign dlt = (hi_v >= lo_v) ? 17'(hi_v - lo_v) : 17'd0;
  assign dprod = 34'(dlt) * 34'(frac);
  assign tdiff = 18'sd65536 - $signed({1'b0, tval});
  assign aprod = 35'(tdiff) * 35'sd44330;
  assign ashift = 27'(aprod >>> 8);
  assign prod2 = $signed({1'b0, 17'(17'd65536 - {1'b0, weight})}) * 43'(filt);
  assign mixsum = 44'(prod1) + 44'(prod2) + 44'sd32768;
  assign mixsh = 28'(mixsum >>> 16);
  assign adiff = 26'(filt) - 26'(prev_alt);
  assign num = 37'(adiff) * 37'sd1000;
  assign mag = num[36] ? 36'(-num) : num[35:0];
  assign dt = now_r - prev_time;

  always_comb begin
    div_start = 1'b0;
    div_dividend = 36'(s_tdata[16:0]) << 16;
    div_divisor = 32'(pref);
    if (state == S_IDLE) begin
      div_start = s_acc && (pref != 17'd0);
    end else if (state == S_SPEED) begin
      div_start = (dt != 32'd0) && (prev_time != 32'd0);
      div_dividend = mag;
      div_divisor = dt;
    end
  end

  bafv_serial_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st),
    .quotient (div_q)
  );

  // configuration writes; indices beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
      pref <= PREF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT: weight <= cfg_data[15:0];
        REG_PREF:   pref <= cfg_data;
        default:    ;
      endcase
    end
  end

  // result valid: set on load, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      filt <= '0;
      prev_alt <= '0;
      prev_time <= '0;
      held <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            now_r <= s_tdata[48:17];
            ratio <= 18'h20000;
            state <= (pref == 17'd0) ? S_POS : S_RATIO;
          end
        end
        S_RATIO: begin
          if (div_st.done) begin
            // clamp ratio to 2.0
            ratio <= (div_q > 36'h20000) ? 18'h20000 : div_q[17:0];
            state <= S_POS;
          end
        end
        S_POS: begin
          idx <= pos[16+IW:17];
          idx_top <= (pos[PW-1:17] >= (PW-17)'(POWER_TABLE_ENTRIES));
          frac <= pos[16:0];
          state <= S_INTERP;
        end
        S_INTERP: begin
          tval <= idx_top ? rom[POWER_TABLE_ENTRIES] : 17'(lo_v + 17'(dprod >> 17));
          state <= S_RAW;
        end
        S_RAW: begin
          if (ashift > 27'sd16777215) raw <= 25'sd16777215;
          else if (ashift < -27'sd16777216) raw <= -25'sd16777216;
          else raw <= 25'(ashift);
          state <= S_MIX1;
        end
        S_MIX1: begin
          prod1 <= $signed({1'b0, weight}) * 42'(raw);
          state <= S_MIX2;
        end
        S_MIX2: begin
          if (mixsh > 28'sd16777215) filt <= 25'sd16777215;
          else if (mixsh < -28'sd16777216) filt <= -25'sd16777216;
          else filt <= 25'(mixsh);
          state <= S_SPEED;
        end
        S_SPEED: begin
          neg <= num[36];
          upd <= div_start;
          state <= div_start ? S_VDIV : S_FIN;
        end
        S_VDIV: begin
          if (div_st.done) begin
            if (neg) held <= (div_q > 36'd8388608) ? -24'sd8388608 : 24'(-div_q);
            else held <= (div_q > 36'd8388607) ? 24'sd8388607 : 24'(div_q);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (m_load) begin
            m_tdata <= {7'd0, held, filt};
            m_tuser <= upd;
            prev_alt <= filt;
            prev_time <= now_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_RATIO || state == S_VDIV))
    else $error("divider finished outside a wait state");

  a_idle_free: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_st.busy)
    else $error("input taken while divider busy");

  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!m_tvalid || m_tready)) |=> (m_tvalid && state == S_IDLE))
    else $error("result not registered on leaving final state");

endmodule
`default_nettype wire

[hw/rtl/bafv_serial_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bafv_serial_div
  import bafv_pkg::*;
#(
  parameter int DW = DIV_DW,
  parameter int VW = DIV_VW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output div_status_t        status,
  output logic      [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [VW:0]   rem_sh;
  logic          take;

  assign rem_sh = {rem, quotient[DW-1]};
  assign take = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift dividend bits out of the top as quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DW-2:0], take};
      rem <= take ? VW'(rem_sh - {1'b0, dvs}) : rem_sh[VW-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire
